[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL of the tempo-map accumulator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tmacc_pkg.sv]
// Types and constants of the tempo-map time accumulator.
// No dependencies.
package tmacc_pkg;

  typedef enum logic {
    OpTempo   = 1'b0,
    OpSongEnd = 1'b1
  } op_e;

  localparam logic CfgTimerFreq = 1'b0;
  localparam logic CfgTpq       = 1'b1;

  localparam int TickW  = 32;
  localparam int TempoW = 24;
  localparam int FreqW  = 32;
  localparam int TpqW   = 15;
  localparam int TimeW  = 64;
  localparam int MulW   = FreqW + TempoW;  // timer_freq * tempo
  localparam int NumW   = MulW + 1;        // plus half the divisor
  localparam int DenW   = 35;              // 1e6 * 32767 fits
  localparam int CfgW   = 32;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [TempoW-1:0] DefaultTempo  = 24'd500000;
  localparam logic [DenW-1:0]   MicrosPerSec  = 35'd1000000;
  localparam logic [FreqW-1:0]  TimerFreqRst  = 32'd1000000000;
  localparam logic [TpqW-1:0]   TpqRst        = 15'd480;

  typedef struct packed {
    logic              operation;
    logic [TickW-1:0]  event_tick;
    logic [TempoW-1:0] tempo_value;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0] time_position;
    logic             song_done;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    logic     song_end;
    in_item_t item;
  } queue_out_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage

[rtl/core/tmacc_front.sv]
// Input side: accepts items, tags song-end items and queues them for the back end.
// Depends on tmacc_pkg.
module tmacc_front import tmacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output queue_out_t q_out_o,
  input  logic       pop_i
);

  typedef struct packed {
    logic     song_end;
    in_item_t item;
  } entry_t;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_stall_o = (cnt_q == QCntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].song_end <= (in_item_i.operation == OpSongEnd);
      mem_q[wr_ptr_q].item     <= in_item_i;
    end
  end

  always_comb begin
    q_out_o.valid    = (cnt_q != '0);
    q_out_o.song_end = mem_q[rd_ptr_q].song_end;
    q_out_o.item     = mem_q[rd_ptr_q].item;
  end

endmodule

[rtl/core/tmacc_div.sv]
// Restoring divider, one quotient bit per cycle, for the tick-time quotient.
// Depends on tmacc_pkg.
module tmacc_div import tmacc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(NumW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_sh;
  logic            ge;

  // remainder stays below the divisor, so one extra bit holds the shifted value
  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rem_sh - {1'b0, den_q}) : DenW'(rem_sh);
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[rtl/core/tmacc_back.sv]
// Execution side: tick time, tick distance product, running time and state.
// Depends on tmacc_pkg, tmacc_div and assert_macros.svh.
`include "assert_macros.svh"

module tmacc_back import tmacc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [FreqW-1:0] timer_freq_i,
  input  logic [TpqW-1:0]  tpq_i,
  input  queue_out_t       q_in_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_PLO  = 3'd4;
  localparam logic [2:0] S_PHI  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [TickW-1:0]  last_tick_q;
  logic [TempoW-1:0] last_tempo_q;
  logic [TimeW-1:0]  acc_q;

  in_item_t          cur_q;
  logic              cur_end_q;
  logic [MulW-1:0]   mul_q;
  logic [DenW-1:0]   den_q;
  logic [TickW-1:0]  diff_q;
  logic [NumW-1:0]   quo_q;
  logic [TimeW-1:0]  plo_q, sum_q, res_q;
  logic [31:0]       phi_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [TpqW-1:0]   res_eff;
  logic              load;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign res_eff = (tpq_i == '0) ? TpqW'(1) : tpq_i;
  assign pop_o   = (state_q == S_IDLE) && q_in_i.valid;
  assign load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign div_req.start = (state_q == S_DIVS);
  assign div_req.num   = NumW'(mul_q) + NumW'(den_q >> 1);
  assign div_req.den   = den_q;

  tmacc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_in_i.valid) state_d = S_MUL;
      S_MUL:   state_d = S_DIVS;
      S_DIVS:  state_d = S_DIVW;
      S_DIVW:  if (div_rsp.done) state_d = S_PLO;
      S_PLO:   state_d = S_PHI;
      S_PHI:   state_d = S_SUM;
      S_SUM:   state_d = S_DONE;
      S_DONE:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_tick_q  <= '0;
      last_tempo_q <= DefaultTempo;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        if (cur_end_q) begin
          last_tick_q  <= '0;
          last_tempo_q <= DefaultTempo;
          acc_q        <= '0;
        end else begin
          last_tick_q  <= cur_q.event_tick;
          last_tempo_q <= cur_q.tempo_value;
          acc_q        <= res_q;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q     <= q_in_i.item;
      cur_end_q <= q_in_i.song_end;
    end
    if (state_q == S_MUL) begin
      mul_q  <= MulW'(timer_freq_i) * MulW'(last_tempo_q);
      den_q  <= MicrosPerSec * DenW'(res_eff);
      diff_q <= cur_q.event_tick - last_tick_q;
    end
    if (state_q == S_DIVW && div_rsp.done) begin
      quo_q <= div_rsp.quo;
    end
    // 32x57 product in two halves; the upper half only matters below bit 64
    if (state_q == S_PLO) begin
      plo_q <= TimeW'(diff_q) * TimeW'(quo_q[31:0]);
    end
    if (state_q == S_PHI) begin
      phi_q <= diff_q * 32'(quo_q[NumW-1:32]);
      sum_q <= acc_q + plo_q;
    end
    if (state_q == S_SUM) begin
      res_q <= sum_q + {phi_q, 32'b0};
    end
    if (load) begin
      out_q.time_position <= res_q;
      out_q.song_done     <= cur_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_NXT(a_end_clears, load && cur_end_q,
              last_tick_q == '0 && acc_q == '0 && last_tempo_q == DefaultTempo,
              "song end did not clear the state")
  `ASSERT_IMP(a_done_in_wait, div_rsp.done, state_q == S_DIVW,
              "divider finished outside the wait state")
  `ASSERT_NXT(a_load_shows, load, out_valid_o && out_item_o.song_done == $past(cur_end_q),
              "loaded result not presented")

endmodule

[rtl/core/midi_tempo_map_time_accumulator_top.sv]
// Top level of the tempo-map time accumulator: configuration registers,
// front queue and back-end sequencer. Depends on tmacc_pkg, tmacc_front, tmacc_back.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  in_item_i  (in_item_t)
//  out      output     out_valid_o/out_stall_i out_item_o (out_item_t)
//  cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// An item passes from the queue head to the output register through the multiply,
// the 57-step restoring divider for the tick time, the two partial products and the sum.
// Two items can wait in the front queue while the back end works.
// Reset restores the register defaults and the start state, and empties the queue.
// A stalled result holds the next one in the back end, and a full queue stalls the input.
module midi_tempo_map_time_accumulator_top import tmacc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o
);

  logic [FreqW-1:0] timer_freq_q;
  logic [TpqW-1:0]  tpq_q;
  queue_out_t       q_out;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_freq_q <= TimerFreqRst;
      tpq_q        <= TpqRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimerFreq: timer_freq_q <= cfg_data_i[FreqW-1:0];
        CfgTpq:       tpq_q        <= cfg_data_i[TpqW-1:0];
        default:      ;
      endcase
    end
  end

  tmacc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_out_o    (q_out),
    .pop_i      (pop)
  );

  tmacc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timer_freq_i (timer_freq_q),
    .tpq_i        (tpq_q),
    .q_in_i       (q_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

[sim/tb_midi_tempo_map_time_accumulator_top.sv]
// Testbench for the tempo-map time accumulator: directed and random tempo-map songs under
// several register settings and idle/stall patterns, checked against a scoreboard model.
// Depends on tmacc_pkg and midi_tempo_map_time_accumulator_top.
`timescale 1ns / 100ps

import tmacc_pkg::*;

class tempo_map_scoreboard;
  logic [FreqW-1:0]  timer_freq;
  logic [TpqW-1:0]   tpq;
  logic [TickW-1:0]  last_tick;
  logic [TempoW-1:0] last_tempo;
  logic [TimeW-1:0]  elapsed;
  out_item_t         expected_q[$];
  int unsigned       mismatches;

  function new();
    timer_freq = TimerFreqRst;
    tpq        = TpqRst;
    mismatches = 0;
    clear_song();
  endfunction

  function void clear_song();
    last_tick  = '0;
    last_tempo = DefaultTempo;
    elapsed    = '0;
  endfunction

  function void set_register(logic idx, logic [CfgW-1:0] data);
    if (idx == CfgTimerFreq) timer_freq = data;
    else tpq = data[TpqW-1:0];
  endfunction

  // rounded timer units per tick under the tempo in force
  function logic [TimeW-1:0] tick_duration();
    logic [TimeW-1:0] den;
    logic [TimeW-1:0] num;
    den = 64'd1000000 * ((tpq == '0) ? 64'd1 : 64'(tpq));
    num = 64'(timer_freq) * 64'(last_tempo);
    return (num + den / 2) / den;
  endfunction

  function void note_input(in_item_t it);
    logic [TickW-1:0] tick_gap;
    out_item_t        exp_item;
    tick_gap = it.event_tick - last_tick;
    exp_item.time_position = elapsed + 64'(tick_gap) * tick_duration();
    exp_item.song_done     = (it.operation == OpSongEnd);
    if (it.operation == OpSongEnd) begin
      clear_song();
    end else begin
      elapsed    = exp_item.time_position;
      last_tick  = it.event_tick;
      last_tempo = it.tempo_value;
    end
    expected_q = {expected_q, exp_item};
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp_item;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected item: time %h done %b", $time, got.time_position,
                 got.song_done);
      return;
    end
    exp_item = expected_q.pop_front();
    if (got.time_position !== exp_item.time_position) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: time_position expected %h got %h", $time,
                 exp_item.time_position, got.time_position);
    end
    if (got.song_done !== exp_item.song_done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: song_done expected %b got %b", $time, exp_item.song_done,
                 got.song_done);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_midi_tempo_map_time_accumulator_top;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 225;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic            cfg_idx = CfgTimerFreq;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_item;

  tempo_map_scoreboard sb;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  midi_tempo_map_time_accumulator_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("** midi_tempo_map_time_accumulator_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = 500;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t mk_item(op_e op, logic [TickW-1:0] tick,
                                       logic [TempoW-1:0] tempo);
    in_item_t it;
    it.operation   = op;
    it.event_tick  = tick;
    it.tempo_value = tempo;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (sender_idle_pct != 0 && $urandom_range(7) == 0) gap = $urandom_range(1, 150);
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] freq, input logic [TpqW-1:0] res);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTimerFreq;
    cfg_data <= freq;
    sb.set_register(CfgTimerFreq, freq);
    @(negedge clk);
    cfg_idx  <= CfgTpq;
    cfg_data <= CfgW'(res);
    sb.set_register(CfgTpq, CfgW'(res));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a sorted tempo map ending in a song end; some noise and dropped endings
  task automatic play_song(input int unsigned n_events);
    logic [TickW-1:0]  tick;
    logic [TempoW-1:0] tempo;
    int unsigned       k;
    int unsigned       r;
    tick = '0;
    for (k = 0; k < n_events; k++) begin
      r = $urandom_range(99);
      if (r < 6) tick = $urandom;
      else if (r < 12) tick = tick + $urandom;
      else if (r >= 20) tick = tick + $urandom_range(1, 4000);
      r = $urandom_range(99);
      if (r < 5) tempo = '0;
      else if (r < 10) tempo = '1;
      else if (r < 25) tempo = TempoW'($urandom);
      else tempo = TempoW'($urandom_range(250000, 1200000));
      send_item(mk_item(OpTempo, tick, tempo));
      if ($urandom_range(99) < 3) return;
    end
    send_item(mk_item(OpSongEnd, tick + $urandom_range(0, 20000), TempoW'($urandom)));
  endtask

  initial begin
    int unsigned p;
    int unsigned target;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    send_item(mk_item(OpTempo, 32'd0, 24'd0));              // zero tempo from tick 0
    send_item(mk_item(OpTempo, 32'd1000, 24'hFFFFFF));      // no time passes at tempo 0
    send_item(mk_item(OpTempo, 32'hFFFF_FFFF, 24'd500000));
    send_item(mk_item(OpTempo, 32'd5, 24'd1));              // tick goes backwards
    send_item(mk_item(OpSongEnd, 32'd0, 24'hFFFFFF));
    send_item(mk_item(OpSongEnd, 32'hFFFF_FFFF, 24'd0));    // back-to-back song ends
    send_item(mk_item(OpTempo, 32'd480, 24'd500000));
    send_item(mk_item(OpTempo, 32'd960, 24'd250000));
    send_item(mk_item(OpSongEnd, 32'd1920, 24'd123456));
    send_item(mk_item(OpTempo, 32'hAAAA_AAAA, 24'hAAAAAA));
    send_item(mk_item(OpTempo, 32'hFFFF_FFFF, 24'h555555));
    send_item(mk_item(OpTempo, 32'h5555_5554, 24'hFFFFFF));
    send_item(mk_item(OpSongEnd, 32'h5555_5555, 24'h555555));
    send_item(mk_item(OpSongEnd, 32'd1, 24'hAAAAAA));

    for (p = 0; p < 8; p++) begin
      wait_results();
      repeat (8) @(negedge clk);
      case (p)
        0: program_regs(32'hFFFF_FFFF, 15'd0);
        1: program_regs(32'd1, 15'd32767);
        2: program_regs(32'd44100, 15'd96);
        3: program_regs(32'd0, 15'd1);
        4: program_regs($urandom, TpqW'($urandom_range(0, 32767)));
        5: program_regs(32'd1000000000, 15'd480);
        6: program_regs($urandom, TpqW'($urandom_range(0, 32767)));
        default: program_regs(32'd48000, 15'd32767);
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 77; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 77; end
        default: begin sender_idle_pct = 32; stall_pct = 32; end
      endcase
      target = items_sent + PhaseItems;
      if (p == 0) begin
        // long receiver hold-off while items keep coming: queue fills, input stalls
        hold_req = 1;
        play_song(12);
      end
      if (p == 1) begin
        play_song(6);
        wait_results();
      end
      while (items_sent < target)
        play_song(($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 9));
    end

    wait_results();
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("** midi_tempo_map_time_accumulator_top: PASSED **");
    end else begin
      $display("** midi_tempo_map_time_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule
